@@ sv/aegis_pkg.sv @@
// ----------------------------------------------------------------------------
// aegis_pkg
// Shared types, constants and AES round function for the AEGIS-256 engine.
// ----------------------------------------------------------------------------
package aegis_pkg;

   localparam int unsigned BLK_W = 128;
   localparam int unsigned NUM_CELLS = 6;
   localparam int unsigned INIT_UPDATES = 16;
   localparam int unsigned FINAL_UPDATES = 7;

   localparam logic [2:0] OP_START   = 3'd0;
   localparam logic [2:0] OP_ABSORB  = 3'd1;
   localparam logic [2:0] OP_ENCRYPT = 3'd2;
   localparam logic [2:0] OP_DECRYPT = 3'd3;
   localparam logic [2:0] OP_FINISH  = 3'd4;

   localparam logic [1:0] CSR_KEY0 = 2'd0;
   localparam logic [1:0] CSR_KEY1 = 2'd1;
   localparam logic [1:0] CSR_KEY2 = 2'd2;
   localparam logic [1:0] CSR_KEY3 = 2'd3;

   localparam logic [127:0] CONST0 = 128'hdd28b57342311120_f12fc26d55183ddb;
   localparam logic [127:0] CONST1 = 128'h6279e99059372215_0d08050302010100;

   typedef logic [127:0] blk_type;

   typedef struct packed {
      logic    load;
      logic    step;
      blk_type data;
   } cell_ctl_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block sits at bits [8i+7:8i]
   function automatic blk_type aes_round(input blk_type a, input blk_type rk);
      logic [7:0] sr [16];
      logic [7:0] a0, a1, a2, a3;
      blk_type r;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sr[i + 4*c] = SBOX[a[8*(i + 4*((c + i) % 4)) +: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
         r[8*(4*c)   +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         r[8*(4*c+1) +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         r[8*(4*c+2) +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         r[8*(4*c+3) +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return r ^ rk;
   endfunction

endpackage

@@ sv/aegis_cell.sv @@
// ----------------------------------------------------------------------------
// aegis_cell
// One 128-bit state block: takes its left neighbor through an AES round
// keyed by its own content; the head cell also folds in the message block.
// ----------------------------------------------------------------------------
module aegis_cell
   import aegis_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  logic         head,
   input  blk_type      init_val,
   input  blk_type      left_val,
   output blk_type      blk_val
);

   blk_type blk_ff, blk_in;

   always_comb begin
      blk_in = blk_ff;
      if (ctl.load) begin
         blk_in = init_val;
      end else if (ctl.step) begin
         blk_in = aes_round(left_val, blk_ff) ^ (head ? ctl.data : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff <= '0;
      end else begin
         blk_ff <= blk_in;
      end
   end

   assign blk_val = blk_ff;

endmodule

@@ sv/aegis_ctrl.sv @@
// ----------------------------------------------------------------------------
// aegis_ctrl
// Request sequencer: decodes opcodes, counts init and length updates,
// tracks bit lengths and holds the response register.
// ----------------------------------------------------------------------------
module aegis_ctrl
   import aegis_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    opcode,
   input  blk_type       w_lo,
   input  blk_type       w_hi,
   input  logic [4:0]    valid_bytes,
   input  blk_type       key_lo,
   input  blk_type       key_hi,
   input  blk_type       s [NUM_CELLS],
   output cell_ctl_type  ctl,
   output blk_type       init_val [NUM_CELLS],
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output blk_type       rsp_blk,
   output logic          rsp_match
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_INIT  = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [63:0] ad_cnt_ff, ad_cnt_in, msg_cnt_ff, msg_cnt_in;
   blk_type kn1_ff, kn1_in, kn2_ff, kn2_in, len_ff, len_in, exp_ff, exp_in;
   blk_type rsp_blk_ff, rsp_blk_in;
   logic rsp_match_ff, rsp_match_in, rsp_valid_ff, rsp_valid_in;
   logic [4:0] nb;
   blk_type mask, wm, ks, ct, tag, ikey;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept = req_tvalid && req_tready;
   assign nb = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         mask[8*i +: 8] = (5'(i) < nb) ? 8'hff : 8'h00;
      end
   end

   assign wm = w_lo & mask;
   assign ks = s[1] ^ s[4] ^ s[5] ^ (s[2] & s[3]);
   assign ct = (wm ^ ks) & mask;
   assign tag = s[0] ^ s[1] ^ s[2] ^ s[3] ^ s[4] ^ s[5];

   assign init_val[0] = key_lo ^ w_lo;
   assign init_val[1] = key_hi ^ w_hi;
   assign init_val[2] = CONST0;
   assign init_val[3] = CONST1;
   assign init_val[4] = key_lo ^ CONST1;
   assign init_val[5] = key_hi ^ CONST0;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: ikey = key_lo;
         2'd1: ikey = key_hi;
         2'd2: ikey = kn1_ff;
         default: ikey = kn2_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ad_cnt_in = ad_cnt_ff;
      msg_cnt_in = msg_cnt_ff;
      kn1_in = kn1_ff;
      kn2_in = kn2_ff;
      len_in = len_ff;
      exp_in = exp_ff;
      rsp_blk_in = rsp_blk_ff;
      rsp_match_in = rsp_match_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctl = '{load: 1'b0, step: 1'b0, data: '0};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_blk_in = '0;
               rsp_match_in = 1'b0;
               case (opcode)
                  OP_START: begin
                     ctl.load = 1'b1;
                     kn1_in = init_val[0];
                     kn2_in = init_val[1];
                     ad_cnt_in = '0;
                     msg_cnt_in = '0;
                     cnt_in = '0;
                     state_in = ST_INIT;
                  end
                  OP_ABSORB, OP_ENCRYPT, OP_DECRYPT: begin
                     rsp_valid_in = 1'b1;
                     if (nb != 5'd0) begin
                        ctl.step = 1'b1;
                        if (opcode == OP_ABSORB) begin
                           ctl.data = wm;
                           ad_cnt_in = ad_cnt_ff + {56'd0, nb, 3'd0};
                        end else begin
                           rsp_blk_in = ct;
                           ctl.data = (opcode == OP_ENCRYPT) ? wm : ct;
                           msg_cnt_in = msg_cnt_ff + {56'd0, nb, 3'd0};
                        end
                     end
                  end
                  OP_FINISH: begin
                     len_in = {msg_cnt_ff, ad_cnt_ff} ^ s[3];
                     exp_in = w_lo;
                     cnt_in = '0;
                     state_in = ST_FINAL;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_INIT: begin
            ctl.step = 1'b1;
            ctl.data = ikey;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(INIT_UPDATES - 1)) begin
               state_in = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         ST_FINAL: begin
            if (cnt_ff == 5'(FINAL_UPDATES)) begin
               rsp_blk_in = tag;
               rsp_match_in = (tag == exp_ff);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ctl.step = 1'b1;
               ctl.data = len_ff;
               cnt_in = cnt_ff + 5'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         ad_cnt_ff <= '0;
         msg_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ad_cnt_ff <= ad_cnt_in;
         msg_cnt_ff <= msg_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kn1_ff <= kn1_in;
      kn2_ff <= kn2_in;
      len_ff <= len_in;
      exp_ff <= exp_in;
      rsp_blk_ff <= rsp_blk_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_blk = rsp_blk_ff;
   assign rsp_match = rsp_match_ff;

endmodule

@@ sv/aegis256_aead_engine.sv @@
// ----------------------------------------------------------------------------
// aegis256_aead_engine
// AEGIS-256 authenticated encryption engine with streaming ports.
// ----------------------------------------------------------------------------
// The state is a ring of six cells, each one AES round wide, all stepping
// together. Absorb, encrypt and decrypt step the ring once if valid_bytes
// is nonzero; start loads the cells, then runs 16 init updates; finish
// captures the length block, runs 7 length updates, then compares the tag.
// One response per request; a new request is taken only once the previous
// response has been taken or is taken in the same cycle. Write the key only
// while idle. Reset clears the state, the bit counters and the key.
module aegis256_aead_engine
   import aegis_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [2:0] opcode, [66:3] word0, [130:67] word1, [194:131] word2,
   // [258:195] word3, [263:259] valid_bytes, [271:264] zero
   input  logic [271:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [63:0] out_word0, [127:64] out_word1, [128] tag_match, [135:129] zero
   output logic [135:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   logic [63:0] key_ff [4];
   cell_ctl_type ctl;
   blk_type init_val [NUM_CELLS];
   blk_type s [NUM_CELLS];
   blk_type rsp_blk;
   logic rsp_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY0: key_ff[0] <= csr_wdata;
            CSR_KEY1: key_ff[1] <= csr_wdata;
            CSR_KEY2: key_ff[2] <= csr_wdata;
            default:  key_ff[3] <= csr_wdata;
         endcase
      end
   end

   aegis_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .opcode      (req_tdata[2:0]),
      .w_lo        (req_tdata[130:3]),
      .w_hi        (req_tdata[258:131]),
      .valid_bytes (req_tdata[263:259]),
      .key_lo      ({key_ff[1], key_ff[0]}),
      .key_hi      ({key_ff[3], key_ff[2]}),
      .s           (s),
      .ctl         (ctl),
      .init_val    (init_val),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_blk     (rsp_blk),
      .rsp_match   (rsp_match)
   );

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      aegis_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .head     (g == 0),
         .init_val (init_val[g]),
         .left_val (s[(g + NUM_CELLS - 1) % NUM_CELLS]),
         .blk_val  (s[g])
      );
   end

   assign rsp_tdata = {7'd0, rsp_match, rsp_blk};

endmodule

@@ sim/tb_aegis256_aead_engine.sv @@
// ----------------------------------------------------------------------------
// tb_aegis256_aead_engine
// Self-checking testbench for the AEGIS-256 engine: an in-bench model of the
// cipher state predicts every response, with bursty requests and a stalling
// response side.
// ----------------------------------------------------------------------------

class aegis_scoreboard;
   typedef logic [127:0] blk_t;
   logic [63:0]  key [4];
   blk_t         st [6];
   logic [63:0]  ad_bits, msg_bits;
   logic [128:0] pending [$];
   int           errors;
   int           checked;

   function new();
      errors = 0;
      checked = 0;
      ad_bits = '0;
      msg_bits = '0;
      foreach (key[i]) key[i] = '0;
      foreach (st[i]) st[i] = '0;
   endfunction

   function void set_key(int idx, logic [63:0] v);
      key[idx] = v;
   endfunction

   static function logic [7:0] dbl(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   static function blk_t round_fn(blk_t a, blk_t rk);
      logic [7:0] sr [16];
      logic [7:0] x0, x1, x2, x3;
      blk_t r;
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++)
            sr[i + 4*c] = aegis_pkg::SBOX[a[8*(i + 4*((c + i) % 4)) +: 8]];
      for (int c = 0; c < 4; c++) begin
         x0 = sr[4*c]; x1 = sr[4*c+1]; x2 = sr[4*c+2]; x3 = sr[4*c+3];
         r[8*(4*c) +: 8]   = dbl(x0) ^ dbl(x1) ^ x1 ^ x2 ^ x3;
         r[8*(4*c+1) +: 8] = x0 ^ dbl(x1) ^ dbl(x2) ^ x2 ^ x3;
         r[8*(4*c+2) +: 8] = x0 ^ x1 ^ dbl(x2) ^ dbl(x3) ^ x3;
         r[8*(4*c+3) +: 8] = dbl(x0) ^ x0 ^ x1 ^ x2 ^ dbl(x3);
      end
      return r ^ rk;
   endfunction

   function void advance(blk_t m);
      blk_t n [6];
      n[0] = round_fn(st[5], st[0]) ^ m;
      for (int i = 1; i < 6; i++) n[i] = round_fn(st[i-1], st[i]);
      st = n;
   endfunction

   function void note_request(logic [271:0] d);
      logic [2:0] op;
      logic [4:0] nb;
      blk_t w, r, k1, k2, kn1, kn2, mask, lenb;
      logic match;
      op = d[2:0];
      nb = d[263:259];
      w = {d[130:67], d[66:3]};
      r = '0;
      match = 1'b0;
      if (nb > 16) nb = 16;
      if (op == aegis_pkg::OP_START) begin
         k1 = {key[1], key[0]};
         k2 = {key[3], key[2]};
         kn1 = k1 ^ w;
         kn2 = k2 ^ {d[258:195], d[194:131]};
         st[0] = kn1; st[1] = kn2;
         st[2] = aegis_pkg::CONST0; st[3] = aegis_pkg::CONST1;
         st[4] = k1 ^ aegis_pkg::CONST1; st[5] = k2 ^ aegis_pkg::CONST0;
         for (int i = 0; i < 4; i++) begin
            advance(k1); advance(k2); advance(kn1); advance(kn2);
         end
         ad_bits = '0;
         msg_bits = '0;
      end else if ((op == aegis_pkg::OP_ABSORB || op == aegis_pkg::OP_ENCRYPT ||
                    op == aegis_pkg::OP_DECRYPT) && nb != 0) begin
         mask = (nb == 16) ? '1 : ((128'd1 << (8 * nb)) - 1);
         w &= mask;
         if (op == aegis_pkg::OP_ABSORB) begin
            advance(w);
            ad_bits += 64'(nb) << 3;
         end else begin
            r = (w ^ st[1] ^ st[4] ^ st[5] ^ (st[2] & st[3])) & mask;
            advance(op == aegis_pkg::OP_ENCRYPT ? w : r);
            msg_bits += 64'(nb) << 3;
         end
      end else if (op == aegis_pkg::OP_FINISH) begin
         lenb = {msg_bits, ad_bits} ^ st[3];
         for (int i = 0; i < 7; i++) advance(lenb);
         r = st[0] ^ st[1] ^ st[2] ^ st[3] ^ st[4] ^ st[5];
         match = (r == w);
      end
      pending.push_back({match, r});
   endfunction

   function void check_response(logic [135:0] d);
      logic [128:0] e;
      checked++;
      if (pending.size() == 0) begin
         $error("response with none expected: %h", d);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (d[63:0] !== e[63:0]) begin
         $error("out_word0 expected %h actual %h", e[63:0], d[63:0]);
         errors++;
      end
      if (d[127:64] !== e[127:64]) begin
         $error("out_word1 expected %h actual %h", e[127:64], d[127:64]);
         errors++;
      end
      if (d[128] !== e[128]) begin
         $error("tag_match expected %b actual %b", e[128], d[128]);
         errors++;
      end
   endfunction
endclass

module tb_aegis256_aead_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import aegis_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [271:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [63:0]  csr_wdata = '0;

   aegis_scoreboard sb = new();
   int  cycles = 0;
   int  sent = 0;
   int  burst_left = 0;
   int  finishes = 0;
   bit  stall_mode = 1'b0;
   logic [127:0] last_tag;

   aegis256_aead_engine DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAILED: results differ");
         $finish;
      end
      if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // response stall pattern: phases of no stall alternating with random stalls
   always @(negedge clock) begin
      if (cycles % 300 == 0) stall_mode <= ~stall_mode;
      rsp_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   task automatic write_key(int idx, logic [63:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx[1:0];
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_key(idx, v);
   endtask

   task automatic send_request(logic [2:0] op, logic [127:0] w, logic [127:0] hi_n,
                               logic [4:0] nb);
      logic [271:0] d;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      d = '0;
      d[2:0] = op;
      d[66:3] = w[63:0];
      d[130:67] = w[127:64];
      d[194:131] = hi_n[63:0];
      d[258:195] = hi_n[127:64];
      d[263:259] = nb;
      req_tdata <= d;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(d);
      sent++;
      if (op == OP_FINISH) finishes++;
      @(negedge clock);
   endtask

   function automatic logic [127:0] rnd128();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic random_message(int len);
      int k;
      logic [4:0] nb;
      send_request(OP_START, rnd128(), rnd128(), 5'd16);
      k = $urandom_range(0, 3);
      for (int i = 0; i < k; i++)
         send_request(OP_ABSORB, rnd128(), rnd128(),
                      (i == k - 1) ? 5'($urandom_range(1, 16)) : 5'd16);
      for (int i = 0; i < len; i++) begin
         nb = (i == len - 1) ? 5'($urandom_range(1, 16)) : 5'd16;
         send_request($urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT, rnd128(), rnd128(), nb);
      end
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0: send_request(3'($urandom_range(5, 7)), rnd128(), rnd128(), 5'($urandom));
            1: send_request(OP_ENCRYPT, rnd128(), rnd128(), 5'd0);
            default: send_request(OP_ABSORB, rnd128(), rnd128(), 5'($urandom_range(17, 31)));
         endcase
      end
      send_request(OP_FINISH, rnd128(), rnd128(), 5'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // requests on the state left by reset, before any start
      send_request(OP_ENCRYPT, '1, '1, 5'd16);
      send_request(OP_ABSORB, '1, '1, 5'd5);
      send_request(OP_FINISH, '0, '0, 5'd16);

      // directed: zero key, extreme fields, all ops and odd cases
      send_request(OP_START, '0, '0, 5'd16);
      send_request(OP_ABSORB, '1, '1, 5'd16);
      send_request(OP_ABSORB, '1, '1, 5'd1);
      send_request(OP_ENCRYPT, '1, '0, 5'd15);
      send_request(OP_DECRYPT, '0, '1, 5'd8);
      send_request(OP_ENCRYPT, '1, '1, 5'd0);
      send_request(OP_DECRYPT, '1, '1, 5'd31);
      send_request(3'd5, '1, '1, 5'd16);
      send_request(3'd7, '1, '1, 5'd31);
      send_request(OP_FINISH, '0, '0, 5'd0);
      send_request(OP_ENCRYPT, rnd128(), '0, 5'd7);
      send_request(OP_FINISH, '1, '1, 5'd16);
      drain();
      foreach (sb.key[i]) write_key(i, '1);
      send_request(OP_START, '1, '1, 5'd16);
      send_request(OP_FINISH, '0, '0, 5'd16);
      drain();
      last_tag = sb.pending.size() == 0 ? '0 : '0;
      // replay same message to hit a matching tag
      send_request(OP_START, 128'h5a, 128'h33, 5'd16);
      send_request(OP_ENCRYPT, 128'h1234, '0, 5'd9);
      send_request(OP_FINISH, '0, '0, 5'd16);
      drain();
      last_tag = sb.st[0] ^ sb.st[1] ^ sb.st[2] ^ sb.st[3] ^ sb.st[4] ^ sb.st[5];
      send_request(OP_START, 128'h5a, 128'h33, 5'd16);
      send_request(OP_ENCRYPT, 128'h1234, '0, 5'd9);
      send_request(OP_FINISH, last_tag, '0, 5'd16);
      drain();

      // random messages under a few keys
      for (int ph = 0; ph < 5; ph++) begin
         foreach (sb.key[i]) write_key(i, {$urandom, $urandom});
         for (int m = 0; m < 23; m++) random_message($urandom_range(1, 12));
         drain();
      end

      $display("Covered %0d requests, %0d finishes, %0d responses checked over seven keys.",
               sent, finishes, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
